// ----- rtl/core/crc32_frame_deframer_macros.svh -----
// Assertion macros shared by the frame deframer modules.
`ifndef CRC32_FRAME_DEFRAMER_MACROS_SVH
`define CRC32_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTH
`define CRCFD_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("deframer assertion failed");
`define CRCFD_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");
`define CRCFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`else
`define CRCFD_ASSERT_ALWAYS(lbl, expr)
`define CRCFD_ASSERT_IMPLIES(lbl, ante, cons)
`define CRCFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/crcfd_pkg.sv -----
// Types, constants and the CRC-32 byte update for the frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package crcfd_pkg;

   localparam int LEN_BITS = 11;
   localparam int LEN_MASK = (1 << LEN_BITS) - 1;
   localparam int OUT_LEN_W = 11;
   localparam int HDR_OVERHEAD = 5;

   localparam logic [7:0] SYNC_BYTE = 8'hA5;
   localparam logic [7:0] END_BYTE = 8'h5A;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [10:0] MAX_TOTAL_RESET = 11'd1280;
   localparam logic [31:0] CRC_SEED_RESET = 32'h35769521;
   localparam logic [7:0] CLASS_BATTERY = 8'h01;
   localparam logic [7:0] ACK_REQUEST = 8'h01;
   localparam logic [7:0] SUB_VOLTAGE = 8'h0C;
   localparam logic [7:0] SUB_CAPACITY = 8'h0B;
   localparam logic [1:0] OUT_DEPTH = 2'd2;

   typedef enum logic [14:0] {
      PH_HUNT = 15'b000000000000001,
      PH_VER  = 15'b000000000000010,
      PH_TL0  = 15'b000000000000100,
      PH_TL1  = 15'b000000000001000,
      PH_CLS  = 15'b000000000010000,
      PH_SUB  = 15'b000000000100000,
      PH_ACK  = 15'b000000001000000,
      PH_DL0  = 15'b000000010000000,
      PH_DL1  = 15'b000000100000000,
      PH_PAY  = 15'b000001000000000,
      PH_CRC0 = 15'b000010000000000,
      PH_CRC1 = 15'b000100000000000,
      PH_CRC2 = 15'b001000000000000,
      PH_CRC3 = 15'b010000000000000,
      PH_END  = 15'b100000000000000
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD   = 1'b0,
      KIND_FRAME_END = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_GOOD    = 2'd0,
      ST_BAD_END = 2'd1,
      ST_BAD_CRC = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RP_NONE     = 2'd0,
      RP_VOLTAGE  = 2'd1,
      RP_CAPACITY = 2'd2
   } reply_type;

   typedef enum logic {
      CSR_MAX_TOTAL = 1'b0,
      CSR_CRC_SEED  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic index;
      logic [31:0] data;
   } csr_wr_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] data_byte;
      logic [OUT_LEN_W-1:0] byte_index;
      logic [7:0] msg_class;
      logic [7:0] msg_sub;
      logic [7:0] ack_code;
      logic [OUT_LEN_W-1:0] payload_length;
      status_type status;
      reply_type reply_kind;
   } rsp_type;

   function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/crcfd_in_stage.sv -----
// Input register stage that holds one received word until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none

module crcfd_in_stage
   import crcfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       room,
   output logic       step,
   output logic [7:0] stage_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign step = valid_ff & room;
   assign req_stall = valid_ff & ~room;
   assign accept = req_valid & ~req_stall;
   assign valid_in = accept | (valid_ff & ~step);
   assign stage_byte = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/crcfd_parser.sv -----
// Frame phase sequencer, CRC-32 accumulator and configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module crcfd_parser
   import crcfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  csr_wr_type csr_wr,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output rsp_type    res
);

`include "crc32_frame_deframer_macros.svh"

   phase_type phase_ff, phase_in;
   logic [LEN_BITS-1:0] tl_ff, tl_in;
   logic [LEN_BITS-1:0] pl_ff, pl_in;
   logic [LEN_BITS-1:0] cnt_ff, cnt_in;
   logic [7:0] class_ff, class_in;
   logic [7:0] sub_ff, sub_in;
   logic [7:0] ack_ff, ack_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] crcrx_ff, crcrx_in;
   logic [10:0] max_ff;
   logic [31:0] seed_ff;

   logic [31:0] crc_upd;
   logic [15:0] tl_full;
   logic [15:0] dl_full;
   logic [LEN_BITS-1:0] cnt_next;

   assign crc_upd = crc32_byte(crc_ff, rx_byte);
   assign tl_full = {rx_byte, tl_ff[7:0]};
   assign dl_full = {rx_byte, pl_ff[7:0]};
   assign cnt_next = cnt_ff + LEN_BITS'(1);

   always_comb begin
      phase_in = phase_ff;
      tl_in = tl_ff;
      pl_in = pl_ff;
      cnt_in = cnt_ff;
      class_in = class_ff;
      sub_in = sub_ff;
      ack_in = ack_ff;
      crc_in = crc_ff;
      crcrx_in = crcrx_ff;
      res_valid = 1'b0;
      res.kind = KIND_PAYLOAD;
      res.data_byte = 8'd0;
      res.byte_index = '0;
      res.msg_class = class_ff;
      res.msg_sub = sub_ff;
      res.ack_code = ack_ff;
      res.payload_length = OUT_LEN_W'(pl_ff);
      res.status = ST_GOOD;
      res.reply_kind = RP_NONE;
      unique case (phase_ff)
         PH_VER: begin
            phase_in = PH_TL0;
         end
         PH_TL0: begin
            tl_in = LEN_BITS'(rx_byte);
            phase_in = PH_TL1;
         end
         PH_TL1: begin
            if ((tl_full > 16'(max_ff)) || (tl_full > 16'(LEN_MASK))) begin
               phase_in = PH_HUNT;
            end else begin
               tl_in = LEN_BITS'(tl_full);
               phase_in = PH_CLS;
            end
         end
         PH_CLS: begin
            class_in = rx_byte;
            crc_in = crc_upd;
            phase_in = PH_SUB;
         end
         PH_SUB: begin
            sub_in = rx_byte;
            crc_in = crc_upd;
            phase_in = PH_ACK;
         end
         PH_ACK: begin
            ack_in = rx_byte;
            crc_in = crc_upd;
            phase_in = PH_DL0;
         end
         PH_DL0: begin
            pl_in = LEN_BITS'(rx_byte);
            crc_in = crc_upd;
            phase_in = PH_DL1;
         end
         PH_DL1: begin
            crc_in = crc_upd;
            if (17'(tl_ff) != (17'(dl_full) + 17'(HDR_OVERHEAD))) begin
               phase_in = PH_HUNT;
            end else begin
               pl_in = LEN_BITS'(dl_full);
               cnt_in = '0;
               crcrx_in = 32'd0;
               phase_in = (LEN_BITS'(dl_full) == '0) ? PH_CRC0 : PH_PAY;
            end
         end
         PH_PAY: begin
            crc_in = crc_upd;
            res_valid = 1'b1;
            res.data_byte = rx_byte;
            res.byte_index = OUT_LEN_W'(cnt_ff);
            cnt_in = cnt_next;
            if (cnt_next >= pl_ff) begin
               phase_in = PH_CRC0;
            end
         end
         PH_CRC0, PH_CRC1, PH_CRC2: begin
            crcrx_in = {rx_byte, crcrx_ff[31:8]};
            phase_in = phase_type'(phase_ff << 1);
         end
         PH_CRC3: begin
            crcrx_in = {rx_byte, crcrx_ff[31:8]};
            phase_in = PH_END;
         end
         PH_END: begin
            res_valid = 1'b1;
            res.kind = KIND_FRAME_END;
            if (rx_byte != END_BYTE) begin
               res.status = ST_BAD_END;
            end else if (~crc_ff != crcrx_ff) begin
               res.status = ST_BAD_CRC;
            end
            if ((rx_byte == END_BYTE) && (~crc_ff == crcrx_ff) && (ack_ff == ACK_REQUEST)
                  && (pl_ff == '0) && (class_ff == CLASS_BATTERY)) begin
               if (sub_ff == SUB_VOLTAGE) begin
                  res.reply_kind = RP_VOLTAGE;
               end else if (sub_ff == SUB_CAPACITY) begin
                  res.reply_kind = RP_CAPACITY;
               end
            end
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == SYNC_BYTE) begin
               crc_in = ~seed_ff;
               phase_in = PH_VER;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         tl_ff <= '0;
         pl_ff <= '0;
         cnt_ff <= '0;
         class_ff <= 8'd0;
         sub_ff <= 8'd0;
         ack_ff <= 8'd0;
         crc_ff <= ~CRC_SEED_RESET;
         crcrx_ff <= 32'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         tl_ff <= tl_in;
         pl_ff <= pl_in;
         cnt_ff <= cnt_in;
         class_ff <= class_in;
         sub_ff <= sub_in;
         ack_ff <= ack_in;
         crc_ff <= crc_in;
         crcrx_ff <= crcrx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_TOTAL_RESET;
         seed_ff <= CRC_SEED_RESET;
      end else if (csr_wr.valid) begin
         unique case (csr_index_type'(csr_wr.index))
            CSR_MAX_TOTAL: max_ff <= csr_wr.data[10:0];
            CSR_CRC_SEED:  seed_ff <= csr_wr.data;
            default: ;
         endcase
      end
   end

   `CRCFD_ASSERT_IMPLIES(a_result_phase, res_valid, (phase_ff == PH_PAY) || (phase_ff == PH_END))
   `CRCFD_ASSERT_NEXT(a_sync_starts, step && (phase_ff == PH_HUNT) && (rx_byte == SYNC_BYTE), phase_ff == PH_VER)
   `CRCFD_ASSERT_NEXT(a_end_rehunts, step && (phase_ff == PH_END), phase_ff == PH_HUNT)

endmodule

`default_nettype wire

// ----- rtl/core/crcfd_out_fifo.sv -----
// Two-entry result queue that keeps the parser running while the output stalls.
`timescale 1ns / 1ps
`default_nettype none

module crcfd_out_fifo
   import crcfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    room,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

`include "crc32_frame_deframer_macros.svh"

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign room = (count_ff != OUT_DEPTH);
   assign out_valid = (count_ff != 2'd0);
   assign out_data = mem_ff[rd_ptr_ff];
   assign pop = out_valid & ~out_stall;
   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CRCFD_ASSERT_ALWAYS(a_no_overflow, !(push && !room))
   `CRCFD_ASSERT_ALWAYS(a_count_bound, count_ff <= OUT_DEPTH)
   `CRCFD_ASSERT_NEXT(a_count_grows, push && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

`default_nettype wire

// ----- rtl/core/crc32_frame_deframer.sv -----
// A word taken into the input register is parsed when it leaves that register; any result
// that it yields is written into the result queue and is shown on rsp_ from there.
// Throughput: one word per cycle, set by the single parser stage between the input
// register and the two-entry result queue; input stalls only while that queue is full.
// Reset is synchronous and active high: the parser returns to sync hunting, the
// configuration registers take their defaults and the result queue empties.
`timescale 1ns / 1ps
`default_nettype none

module crc32_frame_deframer
   import crcfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [10:0] rsp_byte_index,
   output logic [7:0]  rsp_msg_class,
   output logic [7:0]  rsp_msg_sub,
   output logic [7:0]  rsp_ack_code,
   output logic [10:0] rsp_payload_length,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_reply_kind,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic       room;
   logic       step;
   logic [7:0] stage_byte;
   logic       res_valid;
   rsp_type    res;
   rsp_type    head;
   csr_wr_type csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr = {csr_valid & csr_ready, csr_index, csr_data};

   crcfd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_rx_byte(req_rx_byte),
      .room       (room),
      .step       (step),
      .stage_byte (stage_byte)
   );

   crcfd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .csr_wr   (csr_wr),
      .step     (step),
      .rx_byte  (stage_byte),
      .res_valid(res_valid),
      .res      (res)
   );

   crcfd_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (step & res_valid),
      .push_data(res),
      .room     (room),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data (head)
   );

   assign rsp_kind = head.kind;
   assign rsp_data_byte = head.data_byte;
   assign rsp_byte_index = head.byte_index;
   assign rsp_msg_class = head.msg_class;
   assign rsp_msg_sub = head.msg_sub;
   assign rsp_ack_code = head.ack_code;
   assign rsp_payload_length = head.payload_length;
   assign rsp_status = head.status;
   assign rsp_reply_kind = head.reply_kind;

endmodule

`default_nettype wire
